### rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 8;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 4;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 72;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY      = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic push_rear;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

### rtl/circular_deque.sv
// Double-ended queue of signed 32-bit words, DEPTH entries deep.
// Input channel in_*: one transaction per operation. in_tdata carries the
// operation code and the word to push. Codes 5 to 7 behave as a query.
// Output channel out_*: one transaction per operation with the status,
// the front and rear words after the operation (zero while empty), the
// occupancy and the empty and full flags.
// The words sit in a row of cells, front word in the first cell. A push or
// pop at the front shifts the whole row by one place; the rear end moves
// by marking one cell. The rear word is gathered by a registered OR tree
// of clog2(DEPTH) levels, which an operation waits for before its result
// is loaded. A new operation is taken in the cycle after the previous
// result has been loaded into the output register, so the deque takes no
// new operation while the previous one is still in flight.
// Reset empties the deque and drops any pending result; the stored words
// are not cleared. When the receiver stalls, the result holds in the
// output register and a finished operation waits until it can be loaded.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] operation, [34:3] value, [39:35] zero
  input  logic [cdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] front_value, [65:34] rear_value,
  // [69:66] occupancy, [70] is_empty, [71] is_full
  output logic [cdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int LEVELS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEAVES  = 1 << LEVELS;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PHASE_W = $clog2(LEVELS + 2);
  localparam int DW      = cdq_pkg::DATA_W;
  localparam int OW      = cdq_pkg::OCC_W;

  logic [cdq_pkg::OP_W-1:0] op_w;
  cdq_pkg::word_t           value_w;
  logic                     in_fire;
  logic                     is_push;
  logic                     is_pop;
  logic                     full_w;
  logic                     empty_w;
  cdq_pkg::status_t         status_w;
  cdq_pkg::cell_ctrl_t      ctrl_w;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  cdq_pkg::status_t         status_r;
  logic [PHASE_W-1:0]       phase_r;
  logic                     out_valid_r;
  logic [cdq_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                     load_w;

  cdq_pkg::word_t data_q  [DEPTH];
  logic           valid_q [DEPTH];
  cdq_pkg::word_t leaf_w  [LEAVES];
  cdq_pkg::word_t rear_w;
  cdq_pkg::word_t front_w;
  logic [CNT_W+OW-1:0] count_ext;

  assign op_w    = in_tdata[cdq_pkg::OP_W-1:0];
  assign value_w = in_tdata[cdq_pkg::OP_W+DW-1:cdq_pkg::OP_W];
  assign in_fire = in_tvalid && in_tready;
  assign full_w  = (count_r == CNT_W'(DEPTH));
  assign empty_w = (count_r == '0);

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (op_w)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: is_push = 1'b1;
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:   is_pop  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    status_w = cdq_pkg::ST_DONE;
    if (is_push && full_w) begin
      status_w = cdq_pkg::ST_FULL;
    end else if (is_pop && empty_w) begin
      status_w = cdq_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    ctrl_w    = '0;
    count_nxt = count_r;
    if (in_fire && status_w == cdq_pkg::ST_DONE) begin
      unique case (op_w)
        cdq_pkg::OP_PUSH_FRONT: begin
          ctrl_w.shift_right = 1'b1;
          count_nxt          = count_r + 1'b1;
        end
        cdq_pkg::OP_PUSH_REAR: begin
          ctrl_w.push_rear = 1'b1;
          count_nxt        = count_r + 1'b1;
        end
        cdq_pkg::OP_POP_FRONT: begin
          ctrl_w.shift_left = 1'b1;
          count_nxt         = count_r - 1'b1;
        end
        cdq_pkg::OP_POP_REAR: begin
          ctrl_w.pop_rear = 1'b1;
          count_nxt       = count_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_pkg::word_t left_data;
    logic           left_valid;
    cdq_pkg::word_t right_data;
    logic           right_valid;

    if (i == 0) begin : g_first
      assign left_data  = value_w;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_data  = data_q[i-1];
      assign left_valid = valid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_data  = data_q[i+1];
      assign right_valid = valid_q[i+1];
    end

    cdq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl_w),
      .push_data_i  (value_w),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (data_q[i]),
      .valid_o      (valid_q[i]),
      .rear_data_o  (leaf_w[i])
    );
  end

  for (genvar i = DEPTH; i < LEAVES; i++) begin : g_pad
    assign leaf_w[i] = '0;
  end

  cdq_or_tree #(
    .LEVELS(LEVELS)
  ) u_rear_tree (
    .clk   (clk),
    .leaf_i(leaf_w),
    .root_o(rear_w)
  );

  assign front_w   = valid_q[0] ? data_q[0] : '0;
  assign count_ext = {{OW{1'b0}}, count_r};
  assign load_w    = (phase_r == PHASE_W'(LEVELS + 1)) && (!out_valid_r || out_tready);
  assign in_tready = (phase_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= cdq_pkg::ST_DONE;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        status_r <= status_w;
        phase_r  <= PHASE_W'(1);
      end else if (load_w) begin
        phase_r <= '0;
      end else if (phase_r != '0 && phase_r != PHASE_W'(LEVELS + 1)) begin
        phase_r <= phase_r + 1'b1;
      end
      if (load_w) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      out_data_r <= {full_w, empty_w, count_ext[OW-1:0], rear_w, front_w, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/cdq_cell.sv
module cdq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  cdq_pkg::cell_ctrl_t ctrl_i,
  input  cdq_pkg::word_t      push_data_i,
  input  cdq_pkg::word_t      left_data_i,
  input  logic                left_valid_i,
  input  cdq_pkg::word_t      right_data_i,
  input  logic                right_valid_i,
  output cdq_pkg::word_t      data_o,
  output logic                valid_o,
  output cdq_pkg::word_t      rear_data_o
);

  cdq_pkg::word_t data_r;
  cdq_pkg::word_t data_nxt;
  logic           valid_r;
  logic           valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl_i.shift_right) begin
      data_nxt  = left_data_i;
      valid_nxt = left_valid_i;
    end else if (ctrl_i.shift_left) begin
      data_nxt  = right_data_i;
      valid_nxt = right_valid_i;
    end else if (ctrl_i.push_rear) begin
      if (!valid_r && left_valid_i) begin
        data_nxt  = push_data_i;
        valid_nxt = 1'b1;
      end
    end else if (ctrl_i.pop_rear) begin
      if (valid_r && !right_valid_i) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o      = data_r;
  assign valid_o     = valid_r;
  assign rear_data_o = (valid_r && !right_valid_i) ? data_r : '0;

endmodule

### rtl/cdq_or_tree.sv
module cdq_or_tree #(
  parameter int LEVELS = 3
) (
  input  logic           clk,
  input  cdq_pkg::word_t leaf_i [1<<LEVELS],
  output cdq_pkg::word_t root_o
);

  localparam int LEAVES = 1 << LEVELS;

  cdq_pkg::word_t node_r [1:LEAVES-1];
  cdq_pkg::word_t leaf_w [LEAVES:2*LEAVES-1];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      leaf_w[LEAVES+i] = leaf_i[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < LEAVES; i++) begin
      if (2*i >= LEAVES) begin
        node_r[i] <= leaf_w[2*i] | leaf_w[2*i+1];
      end else begin
        node_r[i] <= node_r[2*i] | node_r[2*i+1];
      end
    end
  end

  assign root_o = node_r[1];

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH = cdq_pkg::DEPTH_DEFAULT;
  localparam int DATA_W = cdq_pkg::DATA_W;
  localparam int OP_W = cdq_pkg::OP_W;
  localparam int STATUS_W = cdq_pkg::STATUS_W;
  localparam int OCC_W = cdq_pkg::OCC_W;
  localparam int IN_TDATA_W = cdq_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = cdq_pkg::OUT_TDATA_W;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 256;

  typedef struct {
    logic [OP_W-1:0] op;
    cdq_pkg::word_t  value;
  } deque_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    cdq_pkg::word_t      front_word;
    cdq_pkg::word_t      rear_word;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
  } deque_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  deque_op_t     op_backlog[$];
  deque_report_t predicted_reports[$];

  cdq_pkg::word_t model_slots[DEPTH];
  int unsigned    model_head = 0;
  int unsigned    model_count = 0;

  int queued_count = 0;
  int driven_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int idle_cycles = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int full_reached = 0;

  circular_deque #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic deque_report_t apply_operation(logic [OP_W-1:0] op,
                                                    cdq_pkg::word_t value);
    deque_report_t r;
    r.status = cdq_pkg::ST_DONE;
    if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) begin
      if (model_count == DEPTH) begin
        r.status = cdq_pkg::ST_FULL;
      end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
        model_head = (model_head + DEPTH - 1) % DEPTH;
        model_slots[model_head] = value;
        model_count++;
      end else begin
        model_slots[(model_head + model_count) % DEPTH] = value;
        model_count++;
      end
    end else if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_REAR) begin
      if (model_count == 0) begin
        r.status = cdq_pkg::ST_EMPTY;
      end else begin
        if (op == cdq_pkg::OP_POP_FRONT) begin
          model_head = (model_head + 1) % DEPTH;
        end
        model_count--;
      end
    end
    r.front_word = '0;
    r.rear_word = '0;
    if (model_count != 0) begin
      r.front_word = model_slots[model_head];
      r.rear_word = model_slots[(model_head + model_count - 1) % DEPTH];
    end
    r.occupancy = OCC_W'(model_count);
    r.is_empty = (model_count == 0);
    r.is_full = (model_count == DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic queue_op(logic [OP_W-1:0] op, cdq_pkg::word_t value);
    deque_op_t item;
    item.op = op;
    item.value = value;
    op_backlog.push_back(item);
    queued_count++;
  endtask

  function automatic cdq_pkg::word_t random_word();
    case ($urandom_range(7))
      0: return cdq_pkg::word_t'(32'h7fff_ffff);
      1: return cdq_pkg::word_t'(32'h8000_0000);
      2: return '0;
      3: return cdq_pkg::word_t'(32'hffff_ffff);
      default: return cdq_pkg::word_t'($urandom());
    endcase
  endfunction

  // Bursts that lean toward pushing or popping walk the deque between empty
  // and full, so both rejections and every wrap position come up often.
  task automatic queue_random(int count);
    int left;
    int burst;
    int push_bias;
    int pick;
    logic [OP_W-1:0] op;
    left = count;
    burst = 0;
    push_bias = 50;
    while (left > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(24, 4);
        push_bias = $urandom_range(1) ? 75 : 25;
        if ($urandom_range(3) == 0) begin
          push_bias = 50;
        end
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else if (pick < 10) begin
        op = cdq_pkg::OP_QUERY;
      end else if ($urandom_range(99) < push_bias) begin
        op = $urandom_range(1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
      end else begin
        op = $urandom_range(1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
      end
      queue_op(op, random_word());
      burst--;
      left--;
    end
  endtask

  // Waits until every queued transaction has been driven, accepted and answered.
  task automatic drain();
    while (!(driven_count == queued_count && accepted_count == driven_count &&
             checked_count >= accepted_count)) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(int send_idle, int recv_stall);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    queue_random(PHASE_ITEMS);
    drain();
  endtask

  always @(negedge clk) begin
    deque_op_t item;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || accepted_count == driven_count) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = op_backlog.pop_front();
        in_tdata <= {{(IN_TDATA_W - OP_W - DATA_W){1'b0}}, item.value, item.op};
        in_tvalid <= 1'b1;
        driven_count++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    deque_report_t want;
    logic in_fire;
    logic out_fire;
    in_fire = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    if (rst_n) begin
      if (in_fire) begin
        want = apply_operation(in_tdata[OP_W-1:0], in_tdata[OP_W +: DATA_W]);
        predicted_reports.push_back(want);
        accepted_count++;
        if (want.status == cdq_pkg::ST_FULL) full_rejects++;
        if (want.status == cdq_pkg::ST_EMPTY) empty_rejects++;
        if (want.is_full) full_reached++;
      end
      if (out_fire) begin
        checked_count++;
        if (predicted_reports.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, actual 0x%0h", $time, out_tdata);
        end else begin
          want = predicted_reports.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_tdata[1:0]));
          check_field("front_value", want.front_word, out_tdata[33:2]);
          check_field("rear_value", want.rear_word, out_tdata[65:34]);
          check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(out_tdata[69:66]));
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_tdata[70]));
          check_field("is_full", DATA_W'(want.is_full), DATA_W'(out_tdata[71]));
        end
      end
      idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("[circular_deque] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_op(cdq_pkg::OP_QUERY, '0);
    queue_op(cdq_pkg::OP_POP_FRONT, '0);
    queue_op(cdq_pkg::OP_POP_REAR, cdq_pkg::word_t'(32'hffff_ffff));
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'h7fff_ffff));
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'h8000_0000));
    queue_op(cdq_pkg::OP_QUERY, cdq_pkg::word_t'(32'h1234_5678));
    queue_op(cdq_pkg::OP_POP_REAR, '0);
    queue_op(cdq_pkg::OP_POP_FRONT, '0);
    queue_op(cdq_pkg::OP_PUSH_REAR, '0);
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'hffff_ffff));
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'h0000_0001));
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'h5555_5555));
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'haaaa_aaaa));
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'h7fff_ffff));
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'h8000_0000));
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'h1234_5678));
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'hdead_beef));
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'hcafe_f00d));
    queue_op(OP_SPARE_LO, cdq_pkg::word_t'(32'hffff_ffff));
    queue_op(OP_SPARE_MID, '0);
    queue_op(OP_SPARE_HI, cdq_pkg::word_t'(32'h8000_0000));
    queue_op(cdq_pkg::OP_POP_FRONT, '0);
    queue_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::word_t'(32'h0bad_cafe));
    queue_op(cdq_pkg::OP_POP_REAR, '0);
    queue_op(cdq_pkg::OP_PUSH_REAR, cdq_pkg::word_t'(32'h7654_3210));
    drain();

    run_phase(0, 0);
    run_phase(75, 0);
    run_phase(0, 75);
    run_phase(26, 26);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, predicted_reports.size());
    end

    $display("Checked %0d operations: %0d pushes refused as full, %0d pops refused as empty,",
             checked_count, full_rejects, empty_rejects);
    $display("%0d results at full occupancy, under free, sender-idle, stalled and mixed flow.",
             full_reached);
    if (errors == 0) begin
      $display("[circular_deque] OK");
    end else begin
      $display("[circular_deque] ERROR");
    end
    $finish;
  end

endmodule
